// ----- src/tlb_page_table_translator_unit_macros.svh -----
// Assertion macros for the translator port checker.
// Needs a clk and an active-low rst_n in the including scope.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH

// checked only outside reset
`define TLBPT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tlbpt assertion failed");

// checked during reset too
`define TLBPT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tlbpt reset assertion failed");

`endif

// ----- src/tlbpt_pkg.sv -----
// Shared constants for the TLB / page-table translator.
// No dependencies.
package tlbpt_pkg;

  localparam int ADDR_W = 16;
  localparam int CFG_W  = 9;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 9'd256;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_COUNT_DEF  = 256;
  localparam int MAX_FRAMES_DEF  = 256;
  localparam int PAGE_BYTES_DEF  = 256;

endpackage

// ----- src/tlbpt_in_if.sv -----
// Request channel of the translator: logical address.
// Depends on tlbpt_pkg.
interface tlbpt_in_if import tlbpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink (input valid, input logical_address, output ready);
endinterface

// ----- src/tlbpt_out_if.sv -----
// Result channel of the translator: physical address and lookup outcome.
// Depends on tlbpt_pkg.
interface tlbpt_out_if import tlbpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] physical_address;
  logic              tlb_hit;
  logic              table_hit;
  logic              page_fault;

  modport source (output valid, output physical_address, output tlb_hit,
                  output table_hit, output page_fault, input ready);
  modport sink (input valid, input physical_address, input tlb_hit,
                input table_hit, input page_fault, output ready);
endinterface

// ----- src/tlbpt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/tlb_page_table_translator_unit.sv -----
// TLB and page-table address translator with round-robin frame allocation.
// An accepted request goes from S_OWN to S_CHK_TLB when the TLB holds a
// matching entry, else to S_CHK_PM; S_CHK_TLB goes on to S_CHK_PM when that
// entry names a frame that has since been reallocated. The single read port
// of the frame-owner memory is used for the TLB check and then the page-table
// check. The next request is accepted the cycle after the result is
// registered. After reset a clearing pass over the page map and frame-owner
// memory runs before the first request is taken; cfg writes are taken at any time.
module tlb_page_table_translator_unit import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  tlbpt_in_if.sink         in_chan,
  tlbpt_out_if.source      out_chan,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int FRAME_W   = $clog2(MAX_FRAMES);
  localparam int IDX_W     = $clog2(TLB_ENTRIES);
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CLR_DEPTH = (PAGE_COUNT > MAX_FRAMES) ? PAGE_COUNT : MAX_FRAMES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_OWN, S_CHK_TLB, S_CHK_PM} state_t;

  state_t              state_r;
  logic [CLR_W-1:0]    clr_cnt_r;
  logic [CFG_W-1:0]    frames_in_use_r;
  logic [FRAME_W-1:0]  victim_r;
  logic [IDX_W-1:0]    fill_ptr_r;
  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic [PAGE_W-1:0]   tlb_tag_r [TLB_ENTRIES];
  logic [PAGE_W-1:0]   page_r;
  logic [OFF_W-1:0]    off_r;
  logic                match_r;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_phys_r;
  logic                out_th_r;
  logic                out_ph_r;
  logic                out_pf_r;

  logic                accept;
  logic [PAGE_W-1:0]   in_page;
  logic [OFF_W-1:0]    in_off;
  logic                match_found;
  logic [IDX_W-1:0]    match_idx;
  logic [FRAME_W-1:0]  tlbf_rdata;
  logic [FRAME_W:0]    pm_rdata;
  logic [PAGE_W:0]     own_rdata;
  logic                own_ok;
  logic                pm_ok;
  logic                slot_free;
  logic                clearing;
  logic                finish;
  logic                refill;
  logic                fault_wr;
  logic                own_re;
  logic [FRAME_W-1:0]  own_raddr;
  logic [FRAME_W-1:0]  res_frame;
  logic                res_th;
  logic                res_ph;
  logic                res_pf;
  logic [CMP_W-1:0]    cfg_wide;
  logic [CNT_W-1:0]    eff_n;
  logic [FRAME_W-1:0]  alloc_frame;
  logic [CNT_W-1:0]    alloc_inc;
  logic [FRAME_W-1:0]  victim_nxt;
  logic [IDX_W-1:0]    fill_ptr_nxt;

  assign accept   = in_chan.valid && in_chan.ready;
  assign in_page  = PAGE_W'(in_chan.logical_address >> OFF_W);
  assign in_off   = in_chan.logical_address[OFF_W-1:0];
  assign clearing = (state_r == S_CLEAR);

  assign in_chan.ready             = (state_r == S_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.physical_address = out_phys_r;
  assign out_chan.tlb_hit          = out_th_r;
  assign out_chan.table_hit        = out_ph_r;
  assign out_chan.page_fault       = out_pf_r;

  // lowest matching index wins
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_r[i] && tlb_tag_r[i] == in_page) begin
        match_found = 1'b1;
        match_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cfg_wide = CMP_W'(frames_in_use_r);
    if (frames_in_use_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (cfg_wide > CMP_W'(MAX_FRAMES)) begin
      eff_n = CNT_W'(MAX_FRAMES);
    end else begin
      eff_n = CNT_W'(frames_in_use_r);
    end
  end

  assign alloc_frame  = (CNT_W'(victim_r) < eff_n) ? victim_r : '0;
  assign alloc_inc    = CNT_W'(alloc_frame) + CNT_W'(1);
  assign victim_nxt   = (alloc_inc == eff_n) ? '0 : FRAME_W'(alloc_inc);
  assign fill_ptr_nxt = (fill_ptr_r == IDX_W'(TLB_ENTRIES - 1)) ? '0 : fill_ptr_r + 1'b1;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign own_ok    = own_rdata[PAGE_W] && (own_rdata[PAGE_W-1:0] == page_r);
  assign pm_ok     = pm_rdata[FRAME_W] && own_ok;

  always_comb begin
    finish    = 1'b0;
    refill    = 1'b0;
    fault_wr  = 1'b0;
    own_re    = 1'b0;
    own_raddr = pm_rdata[FRAME_W-1:0];
    res_frame = tlbf_rdata;
    res_th    = 1'b0;
    res_ph    = 1'b0;
    res_pf    = 1'b0;
    unique case (state_r)
      S_CLEAR, S_IDLE: begin
      end
      S_OWN: begin
        own_re    = 1'b1;
        own_raddr = match_r ? tlbf_rdata : pm_rdata[FRAME_W-1:0];
      end
      S_CHK_TLB: begin
        res_th = 1'b1;
        if (own_ok) begin
          finish = slot_free;
        end else begin
          own_re = 1'b1;
        end
      end
      S_CHK_PM: begin
        finish    = slot_free;
        refill    = slot_free;
        fault_wr  = slot_free && !pm_ok;
        res_ph    = pm_ok;
        res_pf    = !pm_ok;
        res_frame = pm_ok ? pm_rdata[FRAME_W-1:0] : alloc_frame;
      end
      default: begin
      end
    endcase
  end

  tlbpt_ram #(.WIDTH(FRAME_W), .DEPTH(TLB_ENTRIES)) u_tlb_frame (
    .clk   (clk),
    .we    (refill),
    .waddr (fill_ptr_r),
    .wdata (res_frame),
    .re    (accept),
    .raddr (match_idx),
    .rdata (tlbf_rdata)
  );

  tlbpt_ram #(.WIDTH(FRAME_W + 1), .DEPTH(PAGE_COUNT)) u_page_map (
    .clk   (clk),
    .we    (clearing || fault_wr),
    .waddr (clearing ? clr_cnt_r[PAGE_W-1:0] : page_r),
    .wdata (clearing ? '0 : {1'b1, alloc_frame}),
    .re    (accept),
    .raddr (in_page),
    .rdata (pm_rdata)
  );

  tlbpt_ram #(.WIDTH(PAGE_W + 1), .DEPTH(MAX_FRAMES)) u_frame_owner (
    .clk   (clk),
    .we    (clearing || fault_wr),
    .waddr (clearing ? clr_cnt_r[FRAME_W-1:0] : alloc_frame),
    .wdata (clearing ? '0 : {1'b1, page_r}),
    .re    (own_re),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  always_ff @(posedge clk) begin
    if (refill) begin
      tlb_tag_r[fill_ptr_r] <= page_r;
    end
    if (accept) begin
      page_r <= in_page;
      off_r  <= in_off;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_cnt_r       <= '0;
      frames_in_use_r <= FRAMES_RESET;
      victim_r        <= '0;
      fill_ptr_r      <= '0;
      tlb_valid_r     <= '0;
      match_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frames_in_use_r <= cfg_wr_data;
      end
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
        out_phys_r  <= ADDR_W'({res_frame, off_r});
        out_th_r    <= res_th;
        out_ph_r    <= res_ph;
        out_pf_r    <= res_pf;
      end
      if (refill) begin
        tlb_valid_r[fill_ptr_r] <= 1'b1;
        fill_ptr_r              <= fill_ptr_nxt;
      end
      if (fault_wr) begin
        victim_r <= victim_nxt;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            match_r <= match_found;
            state_r <= S_OWN;
          end
        end
        S_OWN: begin
          state_r <= match_r ? S_CHK_TLB : S_CHK_PM;
        end
        S_CHK_TLB: begin
          if (!own_ok) begin
            state_r <= S_CHK_PM;
          end else if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        S_CHK_PM: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/tlbpt_checker.sv -----
// Port-level checks for the translator, bound to the top level.
// Depends on tlbpt_pkg and the assertion macro header.
`include "tlb_page_table_translator_unit_macros.svh"

module tlbpt_checker import tlbpt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_physical_address,
  input logic              out_tlb_hit,
  input logic              out_table_hit,
  input logic              out_page_fault
);

  `TLBPT_ASSERT(a_one_outcome, out_valid |-> $onehot({out_tlb_hit, out_table_hit, out_page_fault}))
  `TLBPT_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready)
  `TLBPT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_physical_address)))
  `TLBPT_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_valid && !in_ready))

endmodule

bind tlb_page_table_translator_unit tlbpt_checker u_tlbpt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_chan.valid),
  .in_ready             (in_chan.ready),
  .out_valid            (out_chan.valid),
  .out_ready            (out_chan.ready),
  .out_physical_address (out_chan.physical_address),
  .out_tlb_hit          (out_chan.tlb_hit),
  .out_table_hit        (out_chan.table_hit),
  .out_page_fault       (out_chan.page_fault)
);

// ----- dv/tlbpt_translation_checker.sv -----
// Checker for the TLB / page-table translator: watches both channels and the cfg port,
// predicts each translation and compares every result field. Depends on tlbpt_pkg.
module tlbpt_translation_checker import tlbpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              req_valid,
  input  logic              req_ready,
  input  logic [ADDR_W-1:0] req_address,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  logic [ADDR_W-1:0] rsp_address,
  input  logic              rsp_tlb_hit,
  input  logic              rsp_table_hit,
  input  logic              rsp_page_fault,
  output int                pending_count,
  output int                error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TLB_N  = TLB_ENTRIES_DEF;
  localparam int PAGES  = PAGE_COUNT_DEF;
  localparam int FRAMES = MAX_FRAMES_DEF;

  typedef struct packed {
    logic [ADDR_W-1:0] logical;
    logic [ADDR_W-1:0] phys;
    logic              tlb_hit;
    logic              table_hit;
    logic              page_fault;
  } translation_t;

  logic [CFG_W-1:0] frames_setting;
  bit               tlb_valid [TLB_N];
  logic [7:0]       tlb_page [TLB_N];
  logic [7:0]       tlb_frame [TLB_N];
  int unsigned      tlb_fill_idx;
  bit               map_valid [PAGES];
  logic [7:0]       map_frame [PAGES];
  bit               owner_valid [FRAMES];
  logic [7:0]       owner_page [FRAMES];
  int unsigned      victim_idx;
  translation_t     expected_translations [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic bit frame_owned(input logic [7:0] frame, input logic [7:0] page);
    return owner_valid[frame] && owner_page[frame] == page;
  endfunction

  function automatic void load_tlb(input logic [7:0] page, input logic [7:0] frame);
    tlb_valid[tlb_fill_idx] = 1'b1;
    tlb_page[tlb_fill_idx]  = page;
    tlb_frame[tlb_fill_idx] = frame;
    tlb_fill_idx = (tlb_fill_idx + 1) % TLB_N;
  endfunction

  function automatic translation_t translate_address(input logic [ADDR_W-1:0] addr);
    logic [7:0]   page;
    logic [7:0]   frame;
    int           hit_idx;
    int unsigned  limit;
    translation_t r;
    page    = addr[15:8];
    hit_idx = -1;
    r       = '0;
    for (int i = 0; i < TLB_N; i++) begin
      if (hit_idx < 0 && tlb_valid[i] && tlb_page[i] == page) hit_idx = i;
    end
    // only the lowest matching entry counts, even when stale
    if (hit_idx >= 0 && frame_owned(tlb_frame[hit_idx], page)) begin
      frame     = tlb_frame[hit_idx];
      r.tlb_hit = 1'b1;
    end else if (map_valid[page] && frame_owned(map_frame[page], page)) begin
      frame       = map_frame[page];
      r.table_hit = 1'b1;
      load_tlb(page, frame);
    end else begin
      if (frames_setting == 0) limit = 1;
      else if (frames_setting > FRAMES) limit = FRAMES;
      else limit = frames_setting;
      frame = (victim_idx < limit) ? victim_idx[7:0] : 8'd0;
      victim_idx         = (int'(frame) + 1) % limit;
      owner_valid[frame] = 1'b1;
      owner_page[frame]  = page;
      map_valid[page]    = 1'b1;
      map_frame[page]    = frame;
      r.page_fault       = 1'b1;
      load_tlb(page, frame);
    end
    r.logical = addr;
    r.phys    = {frame, addr[7:0]};
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    translation_t want;
    if (!rst_n) begin
      frames_setting = FRAMES_RESET;
      tlb_fill_idx   = 0;
      victim_idx     = 0;
      for (int i = 0; i < TLB_N; i++) begin
        tlb_valid[i] = 1'b0;
        tlb_page[i]  = '0;
        tlb_frame[i] = '0;
      end
      for (int i = 0; i < PAGES; i++) begin
        map_valid[i] = 1'b0;
        map_frame[i] = '0;
      end
      for (int i = 0; i < FRAMES; i++) begin
        owner_valid[i] = 1'b0;
        owner_page[i]  = '0;
      end
      expected_translations.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_translations.size() == 0) begin
          report_mismatch($sformatf("result %h with no request outstanding", rsp_address));
        end else begin
          want = expected_translations.pop_front();
          if (rsp_address !== want.phys)
            report_mismatch($sformatf("addr %h: physical_address exp %h got %h",
                                      want.logical, want.phys, rsp_address));
          if (rsp_tlb_hit !== want.tlb_hit)
            report_mismatch($sformatf("addr %h: tlb_hit exp %b got %b",
                                      want.logical, want.tlb_hit, rsp_tlb_hit));
          if (rsp_table_hit !== want.table_hit)
            report_mismatch($sformatf("addr %h: table_hit exp %b got %b",
                                      want.logical, want.table_hit, rsp_table_hit));
          if (rsp_page_fault !== want.page_fault)
            report_mismatch($sformatf("addr %h: page_fault exp %b got %b",
                                      want.logical, want.page_fault, rsp_page_fault));
        end
      end
      if (cfg_wr_en) frames_setting = cfg_wr_data;
      if (req_valid && req_ready) expected_translations.push_back(translate_address(req_address));
    end
    pending_count <= expected_translations.size();
  end

endmodule

// ----- dv/tb_tlb_page_table_translator_unit.sv -----
// Testbench top for tlb_page_table_translator_unit: clock, reset, request and result
// traffic with random gaps, frames_in_use phases. Needs tlbpt_pkg, both channel
// interfaces and tlbpt_translation_checker.
module tb_tlb_page_table_translator_unit import tlbpt_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int               pending_count;
  int               error_count;
  int               src_idle_pct;
  int               sink_idle_pct;
  bit               sink_hold;

  tlbpt_in_if  in_if ();
  tlbpt_out_if out_if ();

  tlb_page_table_translator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  tlbpt_translation_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .req_valid     (in_if.valid),
    .req_ready     (in_if.ready),
    .req_address   (in_if.logical_address),
    .rsp_valid     (out_if.valid),
    .rsp_ready     (out_if.ready),
    .rsp_address   (out_if.physical_address),
    .rsp_tlb_hit   (out_if.tlb_hit),
    .rsp_table_hit (out_if.table_hit),
    .rsp_page_fault(out_if.page_fault),
    .pending_count (pending_count),
    .error_count   (error_count)
  );

  always #5ns clk = ~clk;

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_request(input logic [ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.logical_address <= addr;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // waits for every outstanding request to return, then writes frames_in_use
  task automatic write_frames(input logic [CFG_W-1:0] value);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] frames, input int count);
    logic [7:0]        pool [$];
    int                pool_n;
    logic [ADDR_W-1:0] addr;
    write_frames(frames);
    pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 24);
    repeat (pool_n) pool.push_back(8'($urandom_range(0, 255)));
    src_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
    sink_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) addr = ADDR_W'($urandom);
      else addr = {pool[$urandom_range(0, pool_n - 1)], 8'($urandom_range(0, 255))};
      send_request(addr);
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] settings [12];
    in_if.valid           <= 1'b0;
    in_if.logical_address <= '0;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= '0;
    rst_n                 <= 1'b0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_frames(9'd256);
    send_request(16'h0000);
    send_request(16'h00ff);
    send_request(16'hffff);
    send_request(16'hff00);
    send_request(16'h8080);
    send_request(16'h7f7f);
    // shrink below the victim pointer: next fault takes frame 0
    write_frames(9'd2);
    send_request(16'h1234);
    send_request(16'h0011);
    send_request(16'h1200);
    send_request(16'hff01);
    // page 0: lowest TLB match is stale, a later entry is valid
    send_request(16'h0022);
    write_frames(9'd0);
    send_request(16'h5555);
    send_request(16'haaaa);
    send_request(16'h5501);
    write_frames(9'd511);
    send_request(16'h0102);
    send_request(16'h0203);
    send_request(16'h0102);
    send_request(16'hfe80);

    settings = '{9'd256, 9'd1, 9'd511, 9'd0, 9'd17, 9'd3, 9'd300, 9'd128,
                 9'd255, 9'd64, 9'd2, 9'd8};
    settings[4] = CFG_W'($urandom_range(0, 511));
    settings[9] = CFG_W'($urandom_range(0, 511));
    for (int ph = 0; ph < 12; ph++) run_phase(settings[ph], $urandom_range(120, 180));

    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : sink
    int gap_left;
    gap_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (gap_left > 0) begin
        out_if.ready <= 1'b0;
        gap_left--;
      end else begin
        out_if.ready <= !sink_hold;
        gap_left = pick_gap(sink_idle_pct);
      end
    end
  end

  // long result back-pressure while requests keep coming
  initial begin : backpressure
    sink_hold = 1'b0;
    @(posedge rst_n);
    repeat (1500) @(negedge clk);
    sink_hold = 1'b1;
    repeat (500) @(negedge clk);
    sink_hold = 1'b0;
    repeat (3500) @(negedge clk);
    sink_hold = 1'b1;
    repeat (300) @(negedge clk);
    sink_hold = 1'b0;
  end

  initial begin : watchdog
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
